@@ rtl/cbez_pkg.sv @@
package cbez_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CTRL0_X = 3'd0,
        REG_CTRL0_Y = 3'd1,
        REG_CTRL1_X = 3'd2,
        REG_CTRL1_Y = 3'd3,
        REG_CTRL2_X = 3'd4,
        REG_CTRL2_Y = 3'd5,
        REG_CTRL3_X = 3'd6,
        REG_CTRL3_Y = 3'd7
    } cfg_reg_t;

    localparam int CFG_IDX_BITS = 3;
    localparam int NUM_CTRL_PTS = 4;

    // Per-stage load enables of the evaluation pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

@@ rtl/cbez_clamp.sv @@
module cbez_clamp #(
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  cbez_pkg::stage_en_t          en,
    input  logic [PARAM_FRAC_BITS+1:0]   t_param,
    output logic [PARAM_FRAC_BITS:0]     t_out,
    output logic [PARAM_FRAC_BITS:0]     u_out
);
    import cbez_pkg::*;

    localparam int F   = PARAM_FRAC_BITS;
    localparam int T_W = F + 2;
    localparam int P_W = F + 1;
    localparam logic [P_W-1:0] T_ONE = {1'b1, {F{1'b0}}};

    logic [P_W-1:0] t_next, u_next, t_reg, u_reg;

    // Clamp the parameter to [0, 1.0] and form its complement
    always_comb begin
        if (t_param[T_W-1]) begin
            t_next = '0;
        end else if (t_param[P_W-1:0] > T_ONE) begin
            t_next = T_ONE;
        end else begin
            t_next = t_param[P_W-1:0];
        end
        u_next = T_ONE - t_next;
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            t_reg <= t_next;
            u_reg <= u_next;
        end
    end

    assign t_out = t_reg;
    assign u_out = u_reg;

endmodule

@@ rtl/cbez_axis.sv @@
module cbez_axis #(
    parameter int COORD_BITS      = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                                     aclk,
    input  cbez_pkg::stage_en_t                                      en,
    input  logic [cbez_pkg::NUM_CTRL_PTS-1:0][COORD_BITS-1:0]        ctrl,
    input  logic [PARAM_FRAC_BITS:0]                                 t_in,
    input  logic [PARAM_FRAC_BITS:0]                                 u_in,
    output logic [COORD_BITS-1:0]                                    point,
    output logic [COORD_BITS+2:0]                                    tangent
);
    import cbez_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int F      = PARAM_FRAC_BITS;
    localparam int P_W    = F + 1;
    localparam int A_W    = C + F + 1;       // first de Casteljau level, scaled by 1.0
    localparam int B_W    = C + 2 * F + 1;   // second level, scaled by 1.0^2
    localparam int L_W    = B_W / 2;         // low split of a second-level value
    localparam int H_W    = B_W - L_W;       // high split, signed
    localparam int LS_W   = L_W + F + 1;
    localparam int HS_W   = H_W + F + 2;
    localparam int TAN3_W = B_W + 3;         // three times a second-level difference
    localparam int SUM_W  = C + 3 * F + 2;   // point scaled by 1.0^3
    localparam int TAN_W  = C + 3;

    localparam logic signed [SUM_W-1:0]  PT_HALF  =
        $signed({{(SUM_W-1){1'b0}}, 1'b1} << (3 * F - 1));
    localparam logic signed [TAN3_W-1:0] TAN_HALF =
        $signed({{(TAN3_W-1){1'b0}}, 1'b1} << (2 * F - 1));

    // Parameter copies that travel with the data
    logic [P_W-1:0] t2_reg, u2_reg, t3_reg, u3_reg;
    logic signed [P_W:0] t1_sg, u1_sg, t2_sg, u2_sg, t3_sg, u3_sg;

    logic signed [A_W-1:0]    a_next [3];
    logic signed [A_W-1:0]    a_reg  [3];
    logic signed [B_W-1:0]    b_next [2];
    logic signed [B_W-1:0]    b_reg  [2];
    logic [L_W-1:0]           bl0, bl1;
    logic signed [H_W-1:0]    bh0, bh1;
    logic [LS_W-1:0]          ls_next, ls_reg;
    logic signed [HS_W-1:0]   hs_next, hs_reg;
    logic signed [TAN3_W-1:0] diff;
    logic signed [TAN3_W-1:0] tan3_next, tan3_reg;
    logic signed [SUM_W-1:0]  pt_sum;
    logic signed [TAN3_W-1:0] tan_sum;
    logic [C-1:0]             pt_next, pt_reg;
    logic [TAN_W-1:0]         tan_next, tan_reg;

    assign t1_sg = $signed({1'b0, t_in});
    assign u1_sg = $signed({1'b0, u_in});
    assign t2_sg = $signed({1'b0, t2_reg});
    assign u2_sg = $signed({1'b0, u2_reg});
    assign t3_sg = $signed({1'b0, t3_reg});
    assign u3_sg = $signed({1'b0, u3_reg});

    // Stage 2: first interpolation level between neighboring control points
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_next[i] = $signed(ctrl[i]) * u1_sg + $signed(ctrl[i+1]) * t1_sg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= a_next[i];
            end
            t2_reg <= t_in;
            u2_reg <= u_in;
        end
    end

    // Stage 3: second interpolation level
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            b_next[k] = a_reg[k] * u2_sg + a_reg[k+1] * t2_sg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            b_reg[0] <= b_next[0];
            b_reg[1] <= b_next[1];
            t3_reg   <= t2_reg;
            u3_reg   <= u2_reg;
        end
    end

    // Stage 4: last level as split partial products; tangent is 3 (b1 - b0)
    assign bl0 = b_reg[0][L_W-1:0];
    assign bl1 = b_reg[1][L_W-1:0];
    assign bh0 = $signed(b_reg[0][B_W-1:L_W]);
    assign bh1 = $signed(b_reg[1][B_W-1:L_W]);

    always_comb begin
        ls_next   = bl0 * u3_reg + bl1 * t3_reg;
        hs_next   = bh0 * u3_sg + bh1 * t3_sg;
        diff      = TAN3_W'(b_reg[1]) - TAN3_W'(b_reg[0]);
        tan3_next = diff + (diff <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            ls_reg   <= ls_next;
            hs_reg   <= hs_next;
            tan3_reg <= tan3_next;
        end
    end

    // Stage 5: merge partials, round half up and drop the fraction scaling
    always_comb begin
        pt_sum   = (SUM_W'(hs_reg) <<< L_W) + $signed(SUM_W'(ls_reg)) + PT_HALF;
        tan_sum  = tan3_reg + TAN_HALF;
        pt_next  = pt_sum[3*F +: C];
        tan_next = tan_sum[2*F +: TAN_W];
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            pt_reg  <= pt_next;
            tan_reg <= tan_next;
        end
    end

    assign point   = pt_reg;
    assign tangent = tan_reg;

endmodule

@@ rtl/cubic_bezier_point_tangent_top.sv @@
// Cubic Bezier evaluator. Load the four control points through the cfg_wr_*
// port (index 0..7: ctrl0_x, ctrl0_y, ... ctrl3_y, signed Q16.16), then stream
// curve parameters t (1.0 = 2^PARAM_FRAC_BITS, clamped to [0, 1.0]) on the
// s_ side. Each input beat yields one output beat with the curve point and
// the first derivative, both rounded to nearest with ties up. The block takes
// one beat per clock while s_tready is high, through the five-stage
// de Casteljau pipeline (clamp, two interpolation levels, split final
// products, rounding); s_tready falls only when the output is stalled and
// every stage holds a beat. Write configuration only while no beat is in
// flight.
module cubic_bezier_point_tangent_top #(
    parameter int COORD_BITS      = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // configuration write port
    input  logic                                          cfg_wr_en,
    input  logic [cbez_pkg::CFG_IDX_BITS-1:0]             cfg_wr_index,
    input  logic [COORD_BITS-1:0]                         cfg_wr_data,
    // input stream
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // fields from bit 0: t_param
    input  logic [((PARAM_FRAC_BITS+2+7)/8)*8-1:0]        s_tdata,
    // result stream
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // fields from bit 0: point_x, point_y, tangent_x, tangent_y
    output logic [((4*COORD_BITS+6+7)/8)*8-1:0]           m_tdata
);
    import cbez_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = PARAM_FRAC_BITS;
    localparam int OUT_W = ((4 * C + 6 + 7) / 8) * 8;

    logic [7:0][C-1:0] ctrl_reg;
    logic [NUM_CTRL_PTS-1:0][C-1:0] ctrl_x, ctrl_y;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    stage_en_t en;

    logic [F:0]   t_s1, u_s1;
    logic [C-1:0] pt_x, pt_y;
    logic [C+2:0] tan_x, tan_y;

    // Control point registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                REG_CTRL0_X: ctrl_reg[REG_CTRL0_X] <= cfg_wr_data;
                REG_CTRL0_Y: ctrl_reg[REG_CTRL0_Y] <= cfg_wr_data;
                REG_CTRL1_X: ctrl_reg[REG_CTRL1_X] <= cfg_wr_data;
                REG_CTRL1_Y: ctrl_reg[REG_CTRL1_Y] <= cfg_wr_data;
                REG_CTRL2_X: ctrl_reg[REG_CTRL2_X] <= cfg_wr_data;
                REG_CTRL2_Y: ctrl_reg[REG_CTRL2_Y] <= cfg_wr_data;
                REG_CTRL3_X: ctrl_reg[REG_CTRL3_X] <= cfg_wr_data;
                REG_CTRL3_Y: ctrl_reg[REG_CTRL3_Y] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign ctrl_x = {ctrl_reg[REG_CTRL3_X], ctrl_reg[REG_CTRL2_X],
                     ctrl_reg[REG_CTRL1_X], ctrl_reg[REG_CTRL0_X]};
    assign ctrl_y = {ctrl_reg[REG_CTRL3_Y], ctrl_reg[REG_CTRL2_Y],
                     ctrl_reg[REG_CTRL1_Y], ctrl_reg[REG_CTRL0_Y]};

    // Advance a stage when it is empty or the stage after it advances
    always_comb begin
        en.s5 = !v5_reg || m_tready;
        en.s4 = !v4_reg || en.s5;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    always_comb begin
        v1_next = en.s1 ? s_tvalid : v1_reg;
        v2_next = en.s2 ? v1_reg   : v2_reg;
        v3_next = en.s3 ? v2_reg   : v3_reg;
        v4_next = en.s4 ? v3_reg   : v4_reg;
        v5_next = en.s5 ? v4_reg   : v5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    assign s_tready = en.s1;
    assign m_tvalid = v5_reg;

    cbez_clamp #(
        .PARAM_FRAC_BITS(F)
    ) u_clamp (
        .aclk    (aclk),
        .en      (en),
        .t_param (s_tdata[F+1:0]),
        .t_out   (t_s1),
        .u_out   (u_s1)
    );

    cbez_axis #(
        .COORD_BITS      (C),
        .PARAM_FRAC_BITS (F)
    ) u_axis_x (
        .aclk    (aclk),
        .en      (en),
        .ctrl    (ctrl_x),
        .t_in    (t_s1),
        .u_in    (u_s1),
        .point   (pt_x),
        .tangent (tan_x)
    );

    cbez_axis #(
        .COORD_BITS      (C),
        .PARAM_FRAC_BITS (F)
    ) u_axis_y (
        .aclk    (aclk),
        .en      (en),
        .ctrl    (ctrl_y),
        .t_in    (t_s1),
        .u_in    (u_s1),
        .point   (pt_y),
        .tangent (tan_y)
    );

    // Pack the result beat, zero-filled to whole bytes
    assign m_tdata = OUT_W'({tan_y, tan_x, pt_y, pt_x});

endmodule

@@ bench/cubic_bezier_point_tangent_checker.sv @@
`timescale 1ns / 100ps

// Watches both streams and the register port, predicts the curve point and
// slope for every accepted parameter beat, and compares result beats in order.
module cubic_bezier_point_tangent_checker #(
    parameter int COORD_BITS      = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_wr_en,
    input  logic [cbez_pkg::CFG_IDX_BITS-1:0]          cfg_wr_index,
    input  logic [COORD_BITS-1:0]                      cfg_wr_data,
    input  logic                                       s_tvalid,
    input  logic                                       s_tready,
    input  logic [((PARAM_FRAC_BITS+2+7)/8)*8-1:0]     s_tdata,
    input  logic                                       m_tvalid,
    input  logic                                       m_tready,
    input  logic [((4*COORD_BITS+6+7)/8)*8-1:0]        m_tdata,
    output int                                         mismatches,
    output int                                         outstanding
);

    import cbez_pkg::*;

    localparam int T_BITS   = PARAM_FRAC_BITS + 2;
    localparam int TAN_BITS = COORD_BITS + 3;
    localparam int PT_SHIFT = 3 * PARAM_FRAC_BITS;
    localparam int TN_SHIFT = 2 * PARAM_FRAC_BITS;
    localparam logic signed [127:0] T_ONE   = 128'sd1 <<< PARAM_FRAC_BITS;
    localparam logic signed [127:0] PT_HALF = 128'sd1 <<< (PT_SHIFT - 1);
    localparam logic signed [127:0] TN_HALF = 128'sd1 <<< (TN_SHIFT - 1);

    // fields from the lowest bit up: pt_x, pt_y, tan_x, tan_y
    typedef struct packed {
        logic [TAN_BITS-1:0]   tan_y;
        logic [TAN_BITS-1:0]   tan_x;
        logic [COORD_BITS-1:0] pt_y;
        logic [COORD_BITS-1:0] pt_x;
    } curve_sample_t;

    logic signed [COORD_BITS-1:0] hull_x [NUM_CTRL_PTS];
    logic signed [COORD_BITS-1:0] hull_y [NUM_CTRL_PTS];
    curve_sample_t                samples_due [$];
    int                           beat_no;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        beat_no     = 0;
    end

    // Bernstein sum of one axis, rounded half up
    function automatic logic [COORD_BITS-1:0] axis_point(
        input logic signed [COORD_BITS-1:0] p0, p1, p2, p3,
        input logic signed [127:0]          tt, uu);
        logic signed [127:0] w0, w1, w2, w3, acc;
        w0  = p0;
        w1  = p1;
        w2  = p2;
        w3  = p3;
        acc = w0 * uu * uu * uu + 3 * w1 * uu * uu * tt
            + 3 * w2 * uu * tt * tt + w3 * tt * tt * tt;
        acc = (acc + PT_HALF) >>> PT_SHIFT;
        return acc[COORD_BITS-1:0];
    endfunction

    // derivative of one axis from the control differences
    function automatic logic [TAN_BITS-1:0] axis_slope(
        input logic signed [COORD_BITS-1:0] p0, p1, p2, p3,
        input logic signed [127:0]          tt, uu);
        logic signed [127:0] w0, w1, w2, w3, acc;
        w0  = p0;
        w1  = p1;
        w2  = p2;
        w3  = p3;
        acc = 3 * (w1 - w0) * uu * uu + 6 * (w2 - w1) * uu * tt
            + 3 * (w3 - w2) * tt * tt;
        acc = (acc + TN_HALF) >>> TN_SHIFT;
        return acc[TAN_BITS-1:0];
    endfunction

    function automatic curve_sample_t eval_curve(input logic [T_BITS-1:0] t_raw);
        logic signed [127:0] tt, uu;
        curve_sample_t       r;
        // clamp the parameter to [0, 1.0]
        if (t_raw[T_BITS-1]) begin
            tt = 0;
        end else if (t_raw > T_ONE) begin
            tt = T_ONE;
        end else begin
            tt = {{(128-T_BITS){1'b0}}, t_raw};
        end
        uu      = T_ONE - tt;
        r.pt_x  = axis_point(hull_x[0], hull_x[1], hull_x[2], hull_x[3], tt, uu);
        r.pt_y  = axis_point(hull_y[0], hull_y[1], hull_y[2], hull_y[3], tt, uu);
        r.tan_x = axis_slope(hull_x[0], hull_x[1], hull_x[2], hull_x[3], tt, uu);
        r.tan_y = axis_slope(hull_y[0], hull_y[1], hull_y[2], hull_y[3], tt, uu);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s at result beat %0d: got %h, want %h",
                 what, beat_no, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        curve_sample_t got, want;
        if (!aresetn) begin
            foreach (hull_x[i]) begin
                hull_x[i] = '0;
                hull_y[i] = '0;
            end
            samples_due.delete();
        end else begin
            // mirror register writes
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_wr_index))
                    REG_CTRL0_X: hull_x[0] = cfg_wr_data;
                    REG_CTRL0_Y: hull_y[0] = cfg_wr_data;
                    REG_CTRL1_X: hull_x[1] = cfg_wr_data;
                    REG_CTRL1_Y: hull_y[1] = cfg_wr_data;
                    REG_CTRL2_X: hull_x[2] = cfg_wr_data;
                    REG_CTRL2_Y: hull_y[2] = cfg_wr_data;
                    REG_CTRL3_X: hull_x[3] = cfg_wr_data;
                    REG_CTRL3_Y: hull_y[3] = cfg_wr_data;
                    default: ;
                endcase
            end

            // predict on each accepted parameter beat
            if (s_tvalid && s_tready) begin
                samples_due.insert(samples_due.size(), eval_curve(s_tdata[T_BITS-1:0]));
            end

            // compare each accepted result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata[4*COORD_BITS+5:0];
                if (samples_due.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding",
                                    64'(got.pt_x), 64'(0));
                end else begin
                    want = samples_due.pop_front();
                    if (got.pt_x !== want.pt_x) begin
                        report_mismatch("point_x", 64'(got.pt_x), 64'(want.pt_x));
                    end
                    if (got.pt_y !== want.pt_y) begin
                        report_mismatch("point_y", 64'(got.pt_y), 64'(want.pt_y));
                    end
                    if (got.tan_x !== want.tan_x) begin
                        report_mismatch("tangent_x", 64'(got.tan_x), 64'(want.tan_x));
                    end
                    if (got.tan_y !== want.tan_y) begin
                        report_mismatch("tangent_y", 64'(got.tan_y), 64'(want.tan_y));
                    end
                end
                beat_no++;
            end
        end
        outstanding <= samples_due.size();
    end

endmodule

@@ bench/cubic_bezier_point_tangent_top_tb.sv @@
`timescale 1ns / 100ps

module cubic_bezier_point_tangent_top_tb;

    import cbez_pkg::*;

    localparam int COORD_BITS      = 32;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int T_BITS          = PARAM_FRAC_BITS + 2;
    localparam int S_W             = ((PARAM_FRAC_BITS + 2 + 7) / 8) * 8;
    localparam int M_W             = ((4 * COORD_BITS + 6 + 7) / 8) * 8;
    localparam int T_ONE           = 1 << PARAM_FRAC_BITS;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_CURVE = 100;

    localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    cfg_wr_en    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_wr_index = '0;
    logic [COORD_BITS-1:0]   cfg_wr_data  = '0;
    logic                    s_tvalid     = 1'b0;
    logic                    s_tready;
    logic [S_W-1:0]          s_tdata      = '0;
    logic                    m_tvalid;
    logic                    m_tready     = 1'b0;
    logic [M_W-1:0]          m_tdata;

    int mismatches;
    int outstanding;
    int send_idle_pct = 35;
    int recv_idle_pct = 72;
    int hold_requests = 0;
    int holds_taken   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always #1 aclk = ~aclk;

    cubic_bezier_point_tangent_top #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    cubic_bezier_point_tangent_checker #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Result side: random back-pressure, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_requests != holds_taken) begin
            holds_taken <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when no beat or write moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_reg_t r, input logic [COORD_BITS-1:0] v);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= r;
        cfg_wr_data  <= v;
        @(posedge aclk);
    endtask

    task automatic load_curve(input logic [3:0][COORD_BITS-1:0] xs,
                              input logic [3:0][COORD_BITS-1:0] ys);
        write_reg(REG_CTRL0_X, xs[0]);
        write_reg(REG_CTRL0_Y, ys[0]);
        write_reg(REG_CTRL1_X, xs[1]);
        write_reg(REG_CTRL1_Y, ys[1]);
        write_reg(REG_CTRL2_X, xs[2]);
        write_reg(REG_CTRL2_Y, ys[2]);
        write_reg(REG_CTRL3_X, xs[3]);
        write_reg(REG_CTRL3_Y, ys[3]);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one parameter beat, with random gaps ahead of it
    task automatic send_param(input logic [T_BITS-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W-T_BITS){1'b0}}, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            3:       return COORD_BITS'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
            default: return COORD_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [T_BITS-1:0] pick_param();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return T_BITS'($urandom_range(0, T_ONE));
            6: begin
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return T_BITS'(T_ONE);
                    2:       return '1;
                    3:       return T_BITS'(T_ONE + 1);
                    4:       return T_BITS'(1);
                    default: return T_BITS'(T_ONE - 1);
                endcase
            end
            default: return T_BITS'($urandom());
        endcase
    endfunction

    initial begin
        logic [3:0][COORD_BITS-1:0] xs, ys;
        int                         directed_t [11];

        directed_t = '{-131072, -1, 0, 1, 21845, 32768, 43690, 65535, 65536, 65537,
                       131071};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers still at their reset value: flat curve at the origin
        send_param('0);
        send_param(T_BITS'(T_ONE / 2));
        send_param(T_BITS'(T_ONE));

        // zig-zag hull between the coordinate extremes, full parameter sweep
        wait_drain();
        load_curve({C_MAX, C_MIN, C_MAX, C_MIN}, {C_MIN, C_MAX, C_MIN, C_MAX});
        foreach (directed_t[i]) send_param(T_BITS'(directed_t[i]));

        // three idling profiles, several curves each
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 35; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 35; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 4; k++) begin
                wait_drain();
                if (ph == 0 && k == 0) begin
                    xs = {4{C_MIN}};
                    ys = {4{C_MAX}};
                end else if (ph == 1 && k == 0) begin
                    xs = {4{C_MAX}};
                    ys = {4{C_MIN}};
                end else begin
                    foreach (xs[i]) begin
                        xs[i] = pick_coord();
                        ys[i] = pick_coord();
                    end
                end
                load_curve(xs, ys);
                // stall the result side long enough to back up the pipeline
                if (ph == 2 && k == 1) hold_requests <= hold_requests + 1;
                repeat (ITEMS_PER_CURVE) send_param(pick_param());
            end
        end

        // flush and settle, then give the verdict
        wait_drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ cubic_bezier_point_tangent_top.f @@
rtl/cbez_pkg.sv
rtl/cbez_clamp.sv
rtl/cbez_axis.sv
rtl/cubic_bezier_point_tangent_top.sv
bench/cubic_bezier_point_tangent_checker.sv
bench/cubic_bezier_point_tangent_top_tb.sv
